// ===== rtl/wqp_pkg.sv =====
package wqp_pkg;

    // String limits
    localparam logic [6:0] SSID_MAX  = 7'd32;
    localparam logic [6:0] PSK_MAX   = 7'd79;
    localparam logic [6:0] VALUE_MAX = 7'd127;

    // Characters of interest
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    localparam logic [2:0] PREFIX_LEN = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_SSID    = 2'd0;
    localparam logic [1:0] KIND_PSK     = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // Parse status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_PREFIX = 2'd1;
    localparam logic [1:0] ST_NO_COLON   = 2'd2;
    localparam logic [1:0] ST_EMPTY_SSID = 2'd3;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_KEY    = 3'd1,
        PH_COLON  = 3'd2,
        PH_VALUE  = 3'd3,
        PH_DONE   = 3'd4,
        PH_ERROR  = 3'd5
    } t_phase;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] index;
        logic [7:0] value;
        logic [1:0] status;
        logic       hidden;
        logic       open;
        logic [5:0] ssid_len;
        logic [6:0] psk_len;
    } t_result;

    // Results caused by one input item; second slot used only when two is set
    typedef struct packed {
        logic    two;
        t_result res0;
        t_result res1;
    } t_pair;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h57; // W
            3'd1:    c = 8'h49; // I
            3'd2:    c = 8'h46; // F
            3'd3:    c = 8'h49; // I
            3'd4:    c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] true_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h74; // t
            2'd1:    c = 8'h72; // r
            2'd2:    c = 8'h75; // u
            default: c = 8'h65; // e
        endcase
        return c;
    endfunction

    function automatic logic [7:0] nopass_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h6E; // n
            3'd1:    c = 8'h6F; // o
            3'd2:    c = 8'h70; // p
            3'd3:    c = 8'h61; // a
            3'd4:    c = 8'h73; // s
            3'd5:    c = 8'h73; // s
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/wqp_core.sv =====
module wqp_core
    import wqp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    output logic       o_push,
    output t_pair      o_pair
);

    t_phase     r_phase, n_phase;
    logic [2:0] r_prefix_idx, n_prefix_idx;
    logic [7:0] r_key, n_key;
    logic       r_esc, n_esc;
    logic [6:0] r_pos, n_pos;
    logic       r_tm, n_tm;
    logic       r_nm, n_nm;
    logic [5:0] r_ssid_cnt, n_ssid_cnt;
    logic [6:0] r_psk_cnt, n_psk_cnt;
    logic       r_hid, n_hid;
    logic       r_open, n_open;
    logic [1:0] r_err, n_err;

    logic       is_nul;
    logic       vc_do;
    logic [7:0] vc_ch;
    logic       emit;
    logic [1:0] emit_kind;
    logic [6:0] pos_post;
    logic       tm_post;
    logic       nm_post;
    logic       commit_do;
    logic [5:0] ssid_fin;
    logic [6:0] psk_fin;
    logic       hid_fin;
    logic       open_fin;
    logic [1:0] st_fin;
    t_result    char_res;
    t_result    sum_res;

    always_comb begin
        is_nul = (i_byte == CH_NUL);
        vc_ch  = is_nul ? CH_BSLASH : i_byte;

        // a literal value character this cycle (a trailing backslash counts)
        vc_do = (r_phase == PH_VALUE) &&
                (r_esc || (!is_nul && i_byte != CH_BSLASH && i_byte != CH_SEMI));
        commit_do = (r_phase == PH_VALUE) && (is_nul || (!r_esc && i_byte == CH_SEMI));

        emit      = 1'b0;
        emit_kind = KIND_SSID;
        if (vc_do && r_pos < VALUE_MAX) begin
            if (r_key == CH_S && r_pos < SSID_MAX) begin
                emit = 1'b1;
            end else if (r_key == CH_P && r_pos < PSK_MAX) begin
                emit      = 1'b1;
                emit_kind = KIND_PSK;
            end
        end

        pos_post = r_pos;
        tm_post  = r_tm;
        nm_post  = r_nm;
        if (vc_do) begin
            if (r_pos < VALUE_MAX) begin
                pos_post = r_pos + 7'd1;
            end
            if (r_pos >= 7'd4 || true_char(r_pos[1:0]) != vc_ch) begin
                tm_post = 1'b0;
            end
            if (r_pos >= 7'd6 || nopass_char(r_pos[2:0]) != vc_ch) begin
                nm_post = 1'b0;
            end
        end

        ssid_fin = r_ssid_cnt;
        psk_fin  = r_psk_cnt;
        hid_fin  = r_hid;
        open_fin = r_open;
        if (commit_do) begin
            case (r_key)
                CH_S: ssid_fin = (pos_post > SSID_MAX) ? SSID_MAX[5:0] : pos_post[5:0];
                CH_P: psk_fin  = (pos_post > PSK_MAX) ? PSK_MAX : pos_post;
                CH_H: hid_fin  = tm_post && (pos_post == 7'd4);
                CH_T: open_fin = nm_post && (pos_post == 7'd6);
                default: ;
            endcase
        end

        case (r_phase)
            PH_PREFIX: st_fin = ST_BAD_PREFIX;
            PH_COLON:  st_fin = ST_NO_COLON;
            default:   st_fin = r_err;
        endcase
        if (st_fin == ST_OK && ssid_fin == 6'd0) begin
            st_fin = ST_EMPTY_SSID;
        end

        char_res        = '0;
        char_res.kind   = emit_kind;
        char_res.index  = r_pos;
        char_res.value  = vc_ch;

        sum_res         = '0;
        sum_res.kind    = KIND_SUMMARY;
        sum_res.status  = st_fin;
        if (st_fin == ST_OK) begin
            sum_res.hidden   = hid_fin;
            sum_res.open     = open_fin;
            sum_res.ssid_len = ssid_fin;
            sum_res.psk_len  = open_fin ? 7'd0 : psk_fin;
        end

        o_push = emit || is_nul;
        o_pair = '0;
        if (is_nul && emit) begin
            o_pair.two  = 1'b1;
            o_pair.res0 = char_res;
            o_pair.res1 = sum_res;
        end else if (is_nul) begin
            o_pair.res0 = sum_res;
        end else begin
            o_pair.res0 = char_res;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_prefix_idx = r_prefix_idx;
        n_key        = r_key;
        n_esc        = r_esc;
        n_pos        = pos_post;
        n_tm         = tm_post;
        n_nm         = nm_post;
        n_ssid_cnt   = ssid_fin;
        n_psk_cnt    = psk_fin;
        n_hid        = hid_fin;
        n_open       = open_fin;
        n_err        = r_err;

        if (is_nul) begin
            n_phase      = PH_PREFIX;
            n_prefix_idx = 3'd0;
            n_key        = 8'd0;
            n_esc        = 1'b0;
            n_pos        = 7'd0;
            n_tm         = 1'b1;
            n_nm         = 1'b1;
            n_ssid_cnt   = 6'd0;
            n_psk_cnt    = 7'd0;
            n_hid        = 1'b0;
            n_open       = 1'b0;
            n_err        = ST_OK;
        end else begin
            case (r_phase)
                PH_PREFIX: begin
                    if (r_prefix_idx < PREFIX_LEN && prefix_char(r_prefix_idx) == i_byte) begin
                        n_prefix_idx = r_prefix_idx + 3'd1;
                        if (n_prefix_idx == PREFIX_LEN) begin
                            n_phase = PH_KEY;
                        end
                    end else begin
                        n_err   = ST_BAD_PREFIX;
                        n_phase = PH_ERROR;
                    end
                end
                PH_KEY: begin
                    if (i_byte == CH_SEMI) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_key   = i_byte;
                        n_phase = PH_COLON;
                    end
                end
                PH_COLON: begin
                    if (i_byte == CH_COLON) begin
                        n_phase = PH_VALUE;
                        n_esc   = 1'b0;
                        n_pos   = 7'd0;
                        n_tm    = 1'b1;
                        n_nm    = 1'b1;
                    end else begin
                        n_err   = ST_NO_COLON;
                        n_phase = PH_ERROR;
                    end
                end
                PH_VALUE: begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                    end else if (i_byte == CH_BSLASH) begin
                        n_esc = 1'b1;
                    end else if (i_byte == CH_SEMI) begin
                        n_phase = PH_KEY;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_PREFIX;
            r_prefix_idx <= 3'd0;
            r_key        <= 8'd0;
            r_esc        <= 1'b0;
            r_pos        <= 7'd0;
            r_tm         <= 1'b1;
            r_nm         <= 1'b1;
            r_ssid_cnt   <= 6'd0;
            r_psk_cnt    <= 7'd0;
            r_hid        <= 1'b0;
            r_open       <= 1'b0;
            r_err        <= ST_OK;
        end else if (i_take) begin
            r_phase      <= n_phase;
            r_prefix_idx <= n_prefix_idx;
            r_key        <= n_key;
            r_esc        <= n_esc;
            r_pos        <= n_pos;
            r_tm         <= n_tm;
            r_nm         <= n_nm;
            r_ssid_cnt   <= n_ssid_cnt;
            r_psk_cnt    <= n_psk_cnt;
            r_hid        <= n_hid;
            r_open       <= n_open;
            r_err        <= n_err;
        end
    end

endmodule

// ===== rtl/wifi_qr_payload_parser.sv =====
// Channel | Direction | Handshake          | Payload
// input   | in        | i_valid / o_ready  | i_text_byte
// result  | out       | o_valid / i_ready  | o_item_kind .. o_last_of_run
//
// One byte accepted per cycle while o_ready is high. Parser state updates at
// the accepting edge; the byte's results enter a two-entry result queue behind
// any entries already held. A zero byte after a trailing backslash in an S or
// P value below its limit yields two results, the character then the summary.
// o_ready drops only when the queue holds two entries. Synchronous active-low
// reset empties the queue and restarts the parser at the prefix check.
module wifi_qr_payload_parser
    import wqp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_text_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_item_kind,
    output logic [6:0] o_char_index,
    output logic [7:0] o_char_value,
    output logic [1:0] o_parse_status,
    output logic       o_hidden_network,
    output logic       o_open_network,
    output logic [5:0] o_ssid_length,
    output logic [6:0] o_psk_length,
    output logic       o_last_of_run
);

    logic    take;
    logic    push;
    logic    pop;
    t_pair   core_pair;
    t_pair   head;
    t_result cur;

    t_pair      r_fifo [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       r_sub;
    logic [1:0] n_count;

    assign o_ready = (r_count != 2'd2);
    assign take    = i_valid && o_ready;

    wqp_core u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (take),
        .i_byte (i_text_byte),
        .o_push (push),
        .o_pair (core_pair)
    );

    always_comb begin
        head    = r_fifo[r_rd_ptr];
        cur     = r_sub ? head.res1 : head.res0;
        o_valid = (r_count != 2'd0);
        pop     = o_valid && i_ready && (!head.two || r_sub);
        n_count = r_count + {1'b0, take && push} - {1'b0, pop};

        o_item_kind      = cur.kind;
        o_char_index     = cur.index;
        o_char_value     = cur.value;
        o_parse_status   = cur.status;
        o_hidden_network = cur.hidden;
        o_open_network   = cur.open;
        o_ssid_length    = cur.ssid_len;
        o_psk_length     = cur.psk_len;
        o_last_of_run    = r_sub || !head.two;
    end

    always_ff @(posedge i_clk) begin
        if (take && push) begin
            r_fifo[r_wr_ptr] <= core_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_sub    <= 1'b0;
        end else begin
            r_count <= n_count;
            if (take && push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
                r_sub    <= 1'b0;
            end else if (o_valid && i_ready) begin
                r_sub <= 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue overfilled");

    a_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item_kind != KIND_SUMMARY |->
            o_parse_status == ST_OK && o_ssid_length == 6'd0 && o_psk_length == 7'd0)
        else $error("character item carries summary fields");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item_kind == KIND_SUMMARY |-> o_last_of_run)
        else $error("summary not last of run");

    a_ssid_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item_kind == KIND_SSID |-> o_char_index < SSID_MAX)
        else $error("ssid index beyond limit");

    a_sub_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> o_valid && head.two)
        else $error("second result selected without a pair");

endmodule
